[hw/rtl/cvqstg_pkg.sv]
// Package for the CV quantizing square tone generator.
// Holds the request and result types, action codes and the note tables.
// No dependencies.
package cvqstg_pkg;

  // sizes
  localparam int unsigned TickHz    = 1000000;
  localparam int unsigned AdcBits   = 12;
  localparam int unsigned CvW       = AdcBits;
  localparam int unsigned NoteCount = 61;
  localparam int unsigned NoteW     = 6;
  localparam int unsigned NoteDepth = 1 << NoteW;
  localparam int unsigned HalfW     = 16;
  localparam longint unsigned HalfMax = (64'd1 << HalfW) - 64'd1;

  // voltages in units of 0.1 mV
  localparam longint unsigned CvFull      = (64'd1 << AdcBits) - 64'd1;
  localparam longint unsigned FullDeciMv  = 33000;
  localparam longint unsigned ErrDeciMv   = 32000;

  // adc code at which the error threshold is reached
  localparam logic [CvW-1:0] ErrCode =
    CvW'((ErrDeciMv * CvFull + FullDeciMv / 2) / FullDeciMv);

  typedef enum logic [1:0] {
    ActTick = 2'd0,
    ActRise = 2'd1,
    ActFall = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]     action;
    logic [CvW-1:0] cv_code;
  } cvqstg_in_t;

  typedef struct packed {
    logic             wave_level;
    logic             gate_active;
    logic             cv_error;
    logic [NoteW-1:0] note_index;
  } cvqstg_out_t;

  // note thresholds, 0.1 mV
  localparam int unsigned ThrDeciMv [NoteCount] = '{
    0, 540, 1040, 1650, 2000, 2704, 3250, 3810, 3900, 4875, 5395, 5954,
    6500, 7039, 7540, 8200, 8600, 9204, 9750, 10400, 10550, 11375, 11895, 12454,
    13000, 13540, 14040, 14700, 15000, 15704, 16250, 16890, 17200, 17875, 18395, 19050,
    19600, 20040, 20540, 21200, 21700, 22204, 22750, 23500, 23900, 24375, 24895, 25454,
    26100, 26540, 27040, 27800, 28390, 28900, 29250, 29900, 30500, 30875, 31395, 31954,
    32040
  };

  // note frequencies, 0.01 Hz, C0..C5
  localparam int unsigned FreqLowChz [NoteCount] = '{
    1635, 1732, 1835, 1945, 2060, 2183, 2312, 2450, 2596, 2750, 2914, 3087,
    3270, 3465, 3671, 3889, 4120, 4365, 4625, 4900, 5191, 5500, 5827, 6174,
    6541, 6930, 7342, 7778, 8241, 8731, 9250, 9800, 10383, 11000, 11654, 12347,
    13081, 13859, 14683, 15556, 16481, 17461, 18500, 19600, 20765, 22000, 23308, 24694,
    26163, 27718, 29366, 31113, 32963, 34923, 36999, 39200, 41530, 44000, 46616, 49388,
    52325
  };

  // note frequencies, 0.01 Hz, C5..C10
  localparam int unsigned FreqHighChz [NoteCount] = '{
    52325, 55437, 58733, 62225, 65925, 69846, 73999, 78399, 83061, 88000, 93233, 98777,
    104650, 110873, 117466, 124451, 131851, 139691, 147998, 156798, 166122, 176000,
    186466, 197553, 209300, 221746, 234932, 248902, 263702, 279383, 295996, 313596,
    332244, 352000, 372931, 395107, 418601, 443492, 469863, 497803, 527404, 558765,
    591991, 627193, 664488, 704000, 745862, 790213, 837202, 886984, 939727, 995606,
    1054808, 1117530, 1183982, 1254386, 1328975, 1408000, 1491724, 1580426, 1674404
  };

  typedef logic [CvW-1:0]   thr_tab_t  [NoteCount];
  typedef logic [HalfW-1:0] half_tab_t [NoteDepth];

  // thresholds scaled to adc codes with rounding
  function automatic thr_tab_t build_thr_tab();
    thr_tab_t        tab;
    longint unsigned v;
    for (int i = 0; i < NoteCount; i++) begin
      v = (longint'(ThrDeciMv[i]) * CvFull + FullDeciMv / 2) / FullDeciMv;
      tab[i] = CvW'(v);
    end
    return tab;
  endfunction

  // quotient by shift and subtract, only used while building the tables
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // half periods in ticks, rounded and clamped to 1..max
  function automatic half_tab_t build_half_tab(input bit high_oct);
    half_tab_t       tab;
    longint unsigned f;
    longint unsigned h;
    for (int i = 0; i < NoteDepth; i++) begin
      if (i < NoteCount) begin
        f = high_oct ? longint'(FreqHighChz[i]) : longint'(FreqLowChz[i]);
      end else begin
        f = high_oct ? longint'(FreqHighChz[NoteCount-1])
                     : longint'(FreqLowChz[NoteCount-1]);
      end
      h = udiv64(longint'(TickHz) * 100 + f, 2 * f);
      if (h < 1) h = 1;
      if (h > HalfMax) h = HalfMax;
      tab[i] = HalfW'(h);
    end
    return tab;
  endfunction

  localparam thr_tab_t  ThrCode  = build_thr_tab();
  localparam half_tab_t HalfLow  = build_half_tab(1'b0);
  localparam half_tab_t HalfHigh = build_half_tab(1'b1);

endpackage

[hw/rtl/cv_quantizing_square_tone_generator.sv]
// Top level of the CV quantizing square tone generator.
// Depends on cvqstg_pkg for types, action codes and the note tables.
//
// Takes one request per clock: a tick, a gate rise carrying a control-voltage
// code, or a gate fall, and returns one result per request with the wave
// level, gate, error flag and selected note after that request. A request
// passes an input register and then the note search, table lookup and wave
// counter update into the result register, so a new request can be taken
// every cycle; only a stalled result register holds the pipe. The octave
// select is sampled at gate rise and should be written while no request is
// in flight.
module cv_quantizing_square_tone_generator
  import cvqstg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cvqstg_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cvqstg_out_t out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i
);

  logic              octave_q;
  logic              s1_valid_q;
  cvqstg_in_t        s1_q;
  logic              out_valid_q;
  cvqstg_out_t       out_q;

  logic              playing_q, playing_d;
  logic [NoteW-1:0]  note_q, note_d;
  logic              err_q, err_d;
  logic [HalfW-1:0]  cnt_q, cnt_d;
  logic              level_q, level_d;
  logic [HalfW-1:0]  half_q, half_d;

  logic              adv_out;
  logic [NoteW:0]    first_miss;
  logic [NoteW-1:0]  rise_note;
  logic [HalfW:0]    cnt_inc;
  cvqstg_out_t       res_d;

  // flow control
  assign adv_out    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv_out;

  // octave select register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_q <= 1'b0;
    end else if (cfg_we_i) begin
      octave_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // note search: first threshold the code does not reach
  always_comb begin
    first_miss = (NoteW+1)'(NoteCount);
    for (int i = NoteCount - 1; i >= 0; i--) begin
      if (s1_q.cv_code < ThrCode[i]) begin
        first_miss = (NoteW+1)'(i);
      end
    end
    if (s1_q.cv_code >= ErrCode || first_miss == '0) begin
      rise_note = '0;
    end else begin
      rise_note = NoteW'(first_miss - (NoteW+1)'(1));
    end
  end

  assign cnt_inc = {1'b0, cnt_q} + (HalfW+1)'(1);

  // next state per action
  always_comb begin
    playing_d = playing_q;
    note_d    = note_q;
    err_d     = err_q;
    cnt_d     = cnt_q;
    level_d   = level_q;
    half_d    = half_q;
    case (action_e'(s1_q.action))
      ActTick: begin
        if (playing_q) begin
          if (cnt_inc >= {1'b0, half_q}) begin
            cnt_d   = '0;
            level_d = !level_q;
          end else begin
            cnt_d = cnt_inc[HalfW-1:0];
          end
        end
      end
      ActRise: begin
        playing_d = 1'b1;
        note_d    = rise_note;
        if (s1_q.cv_code >= ErrCode) begin
          err_d = 1'b1;
        end
        half_d  = octave_q ? HalfHigh[rise_note] : HalfLow[rise_note];
        cnt_d   = '0;
        level_d = 1'b1;
      end
      ActFall: begin
        playing_d = 1'b0;
        err_d     = 1'b0;
        level_d   = 1'b0;
        cnt_d     = '0;
      end
      default: begin
      end
    endcase
    res_d.wave_level  = playing_d && level_d;
    res_d.gate_active = playing_d;
    res_d.cv_error    = err_d;
    res_d.note_index  = note_d;
  end

  // tone state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      note_q    <= '0;
      err_q     <= 1'b0;
      cnt_q     <= '0;
      level_q   <= 1'b0;
      half_q    <= HalfW'(1);
    end else if (adv_out) begin
      playing_q <= playing_d;
      note_q    <= note_d;
      err_q     <= err_d;
      cnt_q     <= cnt_d;
      level_q   <= level_d;
      half_q    <= half_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> cnt_q < half_q)
    else $error("wave counter reached half period");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> playing_q)
    else $error("error flag set while silent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !playing_q |-> !level_q)
    else $error("wave level high while silent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_out |=> out_valid_q)
    else $error("request lost between input and result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.wave_level |-> out_q.gate_active)
    else $error("wave level without gate");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for cv_quantizing_square_tone_generator: directed and random requests
// checked field by field against a tone predictor. Depends on cvqstg_pkg and the top level.
module tb;
  import cvqstg_pkg::*;

  localparam int unsigned NoteTotal  = 61;
  localparam longint unsigned AdcFull = 4095;
  localparam longint unsigned FullScale = 33000;
  localparam longint unsigned ErrLevel  = 32000;
  localparam longint unsigned TickRate  = 1000000;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PrintLimit = 40;
  localparam logic [1:0] ActSpare = 2'd3;

  // note thresholds in 0.1 mV
  localparam int unsigned NoteMv [NoteTotal] = '{
    0, 540, 1040, 1650, 2000, 2704, 3250, 3810, 3900, 4875, 5395, 5954,
    6500, 7039, 7540, 8200, 8600, 9204, 9750, 10400, 10550, 11375, 11895, 12454,
    13000, 13540, 14040, 14700, 15000, 15704, 16250, 16890, 17200, 17875, 18395, 19050,
    19600, 20040, 20540, 21200, 21700, 22204, 22750, 23500, 23900, 24375, 24895, 25454,
    26100, 26540, 27040, 27800, 28390, 28900, 29250, 29900, 30500, 30875, 31395, 31954,
    32040
  };

  // pitch in 0.01 Hz, lower and upper octave sets
  localparam int unsigned PitchLo [NoteTotal] = '{
    1635, 1732, 1835, 1945, 2060, 2183, 2312, 2450, 2596, 2750, 2914, 3087,
    3270, 3465, 3671, 3889, 4120, 4365, 4625, 4900, 5191, 5500, 5827, 6174,
    6541, 6930, 7342, 7778, 8241, 8731, 9250, 9800, 10383, 11000, 11654, 12347,
    13081, 13859, 14683, 15556, 16481, 17461, 18500, 19600, 20765, 22000, 23308, 24694,
    26163, 27718, 29366, 31113, 32963, 34923, 36999, 39200, 41530, 44000, 46616, 49388,
    52325
  };
  localparam int unsigned PitchHi [NoteTotal] = '{
    52325, 55437, 58733, 62225, 65925, 69846, 73999, 78399, 83061, 88000, 93233, 98777,
    104650, 110873, 117466, 124451, 131851, 139691, 147998, 156798, 166122, 176000,
    186466, 197553, 209300, 221746, 234932, 248902, 263702, 279383, 295996, 313596,
    332244, 352000, 372931, 395107, 418601, 443492, 469863, 497803, 527404, 558765,
    591991, 627193, 664488, 704000, 745862, 790213, 837202, 886984, 939727, 995606,
    1054808, 1117530, 1183982, 1254386, 1328975, 1408000, 1491724, 1580426, 1674404
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  cvqstg_in_t  req_data = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  cvqstg_out_t res_data;
  logic        oct_we = 1'b0;
  logic        oct_data = 1'b0;

  // tone predictor state
  logic        oct_sel = 1'b0;
  logic        tone_on = 1'b0;
  logic [5:0]  tone_note = '0;
  logic        tone_err = 1'b0;
  logic [15:0] tone_cnt = '0;
  logic        tone_lvl = 1'b0;
  logic [15:0] tone_half = 16'd1;

  cvqstg_out_t tone_q [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;

  cv_quantizing_square_tone_generator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_data_i   (req_data),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_data_o  (res_data),
    .cfg_we_i    (oct_we),
    .cfg_data_i  (oct_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // voltage in 0.1 mV to adc code, rounded
  function automatic int unsigned mv_to_code(input longint unsigned deci_mv);
    return int'((deci_mv * AdcFull + FullScale / 2) / FullScale);
  endfunction

  // half period in ticks for a pitch, rounded and clamped
  function automatic logic [15:0] half_ticks(input longint unsigned pitch);
    longint unsigned h;
    h = (TickRate * 100 + pitch) / (2 * pitch);
    if (h < 1) h = 1;
    if (h > 65535) h = 65535;
    return h[15:0];
  endfunction

  // advance the tone state by one request and return the expected result
  function automatic cvqstg_out_t step_tone(input cvqstg_in_t req);
    cvqstg_out_t res;
    int unsigned n;
    logic [16:0] nxt;
    case (req.action)
      ActTick: begin
        if (tone_on) begin
          nxt = {1'b0, tone_cnt} + 17'd1;
          if (nxt >= {1'b0, tone_half}) begin
            tone_cnt = '0;
            tone_lvl = ~tone_lvl;
          end else begin
            tone_cnt = nxt[15:0];
          end
        end
      end
      ActRise: begin
        tone_on = 1'b1;
        if (req.cv_code >= mv_to_code(ErrLevel)) begin
          tone_err  = 1'b1;
          tone_note = '0;
        end else begin
          n = 0;
          while (n < NoteTotal && req.cv_code >= mv_to_code(NoteMv[n])) n++;
          tone_note = (n == 0) ? 6'd0 : 6'(n - 1);
        end
        tone_half = half_ticks(oct_sel ? PitchHi[tone_note] : PitchLo[tone_note]);
        tone_cnt  = '0;
        tone_lvl  = 1'b1;
      end
      ActFall: begin
        tone_on  = 1'b0;
        tone_err = 1'b0;
        tone_lvl = 1'b0;
        tone_cnt = '0;
      end
      default: ;
    endcase
    res.wave_level  = tone_on & tone_lvl;
    res.gate_active = tone_on;
    res.cv_error    = tone_err;
    res.note_index  = tone_note;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("%0t mismatch on result %0d: %s got %0d expected %0d",
               $realtime, results_seen, what, got, want);
  endtask

  // watch both handshakes and the octave write
  always @(posedge clk) begin
    cvqstg_out_t want;
    if (rst_n) begin
      if (oct_we) oct_sel = oct_data;
      if (req_valid && req_ready) tone_q.push_back(step_tone(req_data));
      if (res_valid && res_ready) begin
        if (tone_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = tone_q.pop_front();
          if (res_data.wave_level !== want.wave_level)
            report_mismatch("wave_level", res_data.wave_level, want.wave_level);
          if (res_data.gate_active !== want.gate_active)
            report_mismatch("gate_active", res_data.gate_active, want.gate_active);
          if (res_data.cv_error !== want.cv_error)
            report_mismatch("cv_error", res_data.cv_error, want.cv_error);
          if (res_data.note_index !== want.note_index)
            report_mismatch("note_index", res_data.note_index, want.note_index);
        end
        results_seen++;
      end
    end
  end

  // result side: long hold-off when asked, else random stalls while idle_on is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left--;
    end else begin
      res_ready <= !(idle_on && $urandom_range(99) < 24);
    end
  end

  // run limit
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk) cycle_cnt++;
    $display("[cv_quantizing_square_tone_generator] ERROR");
    $finish;
  end

  // offer one request and wait until it is taken
  task automatic send_req(input logic [1:0] act, input logic [11:0] code);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 24) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid        <= 1'b1;
    req_data.action  <= act;
    req_data.cv_code <= code;
    do @(posedge clk); while (!req_ready);
  endtask

  // stop offering and wait for every pending result
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_octave(input logic hi);
    wait_drained();
    @(negedge clk);
    oct_we   <= 1'b1;
    oct_data <= hi;
    @(negedge clk);
    oct_we   <= 1'b0;
  endtask

  // code near a random threshold, near the error level or anywhere
  function automatic logic [11:0] pick_code();
    longint c;
    c = longint'(mv_to_code(NoteMv[$urandom_range(NoteTotal - 1)]))
        + longint'($urandom_range(2)) - 1;
    case ($urandom_range(3))
      0: c = $urandom_range(4095);
      1: c = $urandom_range(4095, 3940);
      default: ;
    endcase
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c[11:0];
  endfunction

  // ticks and falls while silent, spare action code
  task automatic test_idle_actions();
    write_octave(1'b0);
    send_req(ActTick, 12'hfff);
    send_req(ActFall, 12'h000);
    send_req(ActSpare, 12'hfff);
    send_req(ActSpare, 12'h000);
  endtask

  // threshold edges, error level, restart while playing, note kept after fall
  task automatic test_quantize_edges();
    int unsigned err_code;
    err_code = mv_to_code(ErrLevel);
    send_req(ActRise, 12'd0);
    send_req(ActTick, 12'hfff);
    send_req(ActRise, 12'hfff);
    send_req(ActTick, 12'h000);
    send_req(ActRise, 12'd500);
    send_req(ActFall, 12'h000);
    send_req(ActRise, 12'(mv_to_code(NoteMv[1])));
    send_req(ActRise, 12'(mv_to_code(NoteMv[1]) - 1));
    send_req(ActRise, 12'(mv_to_code(NoteMv[30])));
    send_req(ActRise, 12'(mv_to_code(NoteMv[30]) - 1));
    send_req(ActRise, 12'(err_code - 1));
    send_req(ActRise, 12'(err_code));
    send_req(ActSpare, 12'h555);
    send_req(ActFall, 12'haaa);
    send_req(ActTick, 12'h000);
    send_req(ActFall, 12'hfff);
  endtask

  // upper octave: short half periods so the wave toggles often
  task automatic test_high_octave_wave();
    write_octave(1'b1);
    send_req(ActRise, 12'(mv_to_code(ErrLevel) - 1));
    repeat (80) send_req(ActTick, 12'($urandom()));
    send_req(ActRise, 12'd0);
    repeat (10) send_req(ActTick, 12'($urandom()));
    send_req(ActFall, 12'($urandom()));
  endtask

  // lower octave: one long half period runs out
  task automatic test_low_octave_wave();
    write_octave(1'b0);
    idle_on = 1'b0;
    send_req(ActRise, 12'(mv_to_code(NoteMv[59])));
    repeat (1020) send_req(ActTick, 12'($urandom()));
    send_req(ActFall, 12'($urandom()));
    idle_on = 1'b1;
  endtask

  // result side held off while requests keep coming, then a full pause
  task automatic test_backpressure();
    write_octave(1'b1);
    stall_left = 300;
    send_req(ActRise, pick_code());
    repeat (40) send_req(ActTick, 12'($urandom()));
    wait_drained();
    send_req(ActFall, 12'($urandom()));
  endtask

  // note sequences with random content, mixed with noise requests
  task automatic test_random_tones(input logic hi, input bit gaps, input int n_items);
    int sent;
    int ticks;
    write_octave(hi);
    idle_on = gaps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        send_req(ActRise, pick_code());
        ticks = $urandom_range(150);
        repeat (ticks) send_req(ActTick, 12'($urandom()));
        sent += ticks + 1;
        if ($urandom_range(2) == 0) begin
          send_req(ActFall, 12'($urandom()));
          sent++;
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_req(2'($urandom_range(3)), 12'($urandom()));
          sent++;
        end
      end
      if ($urandom_range(19) == 0) wait_drained();
    end
    idle_on = 1'b1;
  endtask

  // test sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_actions();
    test_quantize_edges();
    test_high_octave_wave();
    test_low_octave_wave();
    test_backpressure();
    test_random_tones(1'b1, 1'b1, 80);
    test_random_tones(1'b0, 1'b1, 80);
    test_random_tones(1'b1, 1'b0, 80);
    test_random_tones(1'b1, 1'b1, 80);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[cv_quantizing_square_tone_generator] OK");
    end else begin
      $display("[cv_quantizing_square_tone_generator] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cvqstg_pkg.sv
hw/rtl/cv_quantizing_square_tone_generator.sv
verif/tb.sv
